// File: hw/rtl/gbs_pkg.sv
// Shared constants for the greedy box suppression block.
`default_nettype none
package gbs_pkg;
  localparam int unsigned SCORE_BITS = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [SCORE_BITS-1:0] THRESH_RESET = 16'd13107;
endpackage
`default_nettype wire

// File: hw/rtl/gbs_box_mem.sv
// Candidate box store: one write port, one registered read port.
`default_nettype none
module gbs_box_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/gbs_iou.sv
// Pipelined exact overlap test: inter * 2^16 > threshold * union.
`default_nettype none
module gbs_iou
  import gbs_pkg::*;
#(
  parameter int unsigned C    = 12,
  parameter int unsigned TAGW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [TAGW-1:0]       in_tag,
  input  wire logic [C-1:0]          j_left,
  input  wire logic [C-1:0]          j_top,
  input  wire logic [C-1:0]          j_w,
  input  wire logic [C-1:0]          j_h,
  input  wire logic [C-1:0]          k_left,
  input  wire logic [C-1:0]          k_top,
  input  wire logic [C-1:0]          k_w,
  input  wire logic [C-1:0]          k_h,
  input  wire logic [SCORE_BITS-1:0] thr,
  output logic                       out_valid,
  output logic                       out_over,
  output logic [TAGW-1:0]            out_tag,
  output logic                       busy
);
  localparam int unsigned E    = C + 1;
  localparam int unsigned IW   = 2 * E;
  localparam int unsigned UW   = 2 * C + 2;
  localparam int unsigned CMPW = IW + FRAC_BITS;

  logic [E-1:0] jr, kr, jb, kb, x1, x2, y1, y2, ix, iy;
  logic v1, v2, v3, v4;
  logic [TAGW-1:0] tag1, tag2, tag3, tag4;
  logic [E-1:0] ix1, iy1;
  logic [2*C-1:0] aj1, ak1, aj2, ak2;
  logic [IW-1:0] inter2, inter3;
  logic [UW-1:0] uni3;
  logic [CMPW-1:0] lhs4, prod4;

  // intersection extents
  always_comb begin
    jr = {1'b0, j_left} + {1'b0, j_w};
    kr = {1'b0, k_left} + {1'b0, k_w};
    jb = {1'b0, j_top} + {1'b0, j_h};
    kb = {1'b0, k_top} + {1'b0, k_h};
    x1 = (j_left > k_left) ? {1'b0, j_left} : {1'b0, k_left};
    y1 = (j_top > k_top) ? {1'b0, j_top} : {1'b0, k_top};
    x2 = (jr < kr) ? jr : kr;
    y2 = (jb < kb) ? jb : kb;
    ix = (x2 > x1) ? x2 - x1 : '0;
    iy = (y2 > y1) ? y2 - y1 : '0;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; out_valid <= v4;
    end
    tag1 <= in_tag; tag2 <= tag1; tag3 <= tag2; tag4 <= tag3; out_tag <= tag4;
    ix1 <= ix;
    iy1 <= iy;
    aj1 <= j_w * j_h;
    ak1 <= k_w * k_h;
    inter2 <= ix1 * iy1;
    aj2 <= aj1;
    ak2 <= ak1;
    uni3 <= UW'(ak2) + UW'(aj2) - UW'(inter2);
    inter3 <= inter2;
    lhs4 <= {inter3, {FRAC_BITS{1'b0}}};
    // full-width product: 16 x 26 bits into the compare width
    prod4 <= thr * uni3;
    out_over <= lhs4 > prod4;
  end

  assign busy = v1 | v2 | v3 | v4 | out_valid;
endmodule
`default_nettype wire

// File: hw/rtl/greedy_box_suppression.sv
// Top level: greedy non-maximum suppression over a set of candidate boxes.
//
//  group | direction | payload
//  s_*   | in        | s_tdata {left,top,width,height,score}, s_tlast = set_end
//  m_*   | out       | m_tdata {left,top,width,height,score}, m_tlast = final_kept,
//        |           | m_tuser = overflowed
//  cfg_* | in        | cfg_data = iou_threshold (Q0.16)
//
// Loading accepts one box per cycle. After the set end, there is one round per
// kept box plus one more, each a scan of the n stored boxes through the memory
// read port, a drain of the overlap pipeline and one selection step.
// Reset clears control state and sets the threshold to about 0.20.
// Results wait in an output register; the selection step stalls while a kept box
// is waiting to go out and that register is full and not being accepted.
`default_nettype none
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  // left, top, width, height, score (low to high), zero padded
  input  wire logic [((4*COORD_BITS+SCORE_BITS+7)/8)*8-1:0] s_tdata,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic s_tlast,
  // kept left, top, width, height, score (low to high), zero padded
  output logic [((4*COORD_BITS+SCORE_BITS+7)/8)*8-1:0] m_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output logic      m_tlast,
  // overflowed
  output logic      m_tuser,
  input  wire logic [SCORE_BITS-1:0] cfg_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready
);
  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned BW   = 4 * C + SCORE_BITS;
  localparam int unsigned DW   = ((BW + 7) / 8) * 8;
  localparam int unsigned IDXW = $clog2(MAX_BOXES);
  localparam int unsigned CNTW = $clog2(MAX_BOXES + 1);
  localparam int unsigned TAGW = BW + IDXW + 1;

  typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_DRAIN, ST_NEXT} state_t;

  state_t state;
  logic [SCORE_BITS-1:0] thr;
  logic [CNTW-1:0] count, scnt;
  logic ovf;
  logic [MAX_BOXES-1:0] taken, supp;
  logic have_k;
  logic [BW-1:0] kbox;
  logic best_found;
  logic [BW-1:0] best_box;
  logic [IDXW-1:0] best_idx;
  logic iss_v, iss_act;
  logic [IDXW-1:0] iss_idx;
  logic [BW-1:0] rd_data;
  logic in_xfer, wr_en;
  logic [IDXW-1:0] rd_addr;
  logic p_valid, p_over, p_busy, p_act;
  logic [TAGW-1:0] p_tag;
  logic [IDXW-1:0] p_idx;
  logic [BW-1:0] p_box;
  logic out_free;

  assign s_tready = (state == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign in_xfer = s_tvalid & s_tready;
  assign wr_en = in_xfer & (count < CNTW'(MAX_BOXES));
  assign rd_addr = scnt[IDXW-1:0];
  assign out_free = ~m_tvalid | m_tready;
  assign p_act = p_tag[TAGW-1];
  assign p_idx = p_tag[TAGW-2 -: IDXW];
  assign p_box = p_tag[BW-1:0];

  gbs_box_mem #(.DEPTH(MAX_BOXES), .WIDTH(BW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(count[IDXW-1:0]),
    .wr_data(s_tdata[BW-1:0]), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  gbs_iou #(.C(C), .TAGW(TAGW)) u_iou (
    .clk(clk), .rst(rst), .in_valid(iss_v),
    .in_tag({iss_act, iss_idx, rd_data}),
    .j_left(rd_data[C-1:0]), .j_top(rd_data[2*C-1:C]),
    .j_w(rd_data[3*C-1:2*C]), .j_h(rd_data[4*C-1:3*C]),
    .k_left(kbox[C-1:0]), .k_top(kbox[2*C-1:C]),
    .k_w(kbox[3*C-1:2*C]), .k_h(kbox[4*C-1:3*C]),
    .thr(thr), .out_valid(p_valid), .out_over(p_over), .out_tag(p_tag), .busy(p_busy)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_valid & cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // sequencer: load, scan, drain, select next kept box
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      scnt <= '0;
      ovf <= 1'b0;
      taken <= '0;
      supp <= '0;
      have_k <= 1'b0;
      best_found <= 1'b0;
      iss_v <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      iss_v <= (state == ST_SCAN);
      // output transfer done, unless a new kept box replaces it this cycle
      if (m_tvalid & m_tready & ~((state == ST_NEXT) & have_k)) begin
        m_tvalid <= 1'b0;
      end
      // pipeline results: suppress or track best remaining box
      if (p_valid) begin
        if (have_k & p_over) begin
          supp[p_idx] <= 1'b1;
        end else if (p_act & (~best_found | (p_box[BW-1 -: SCORE_BITS] >
                                             best_box[BW-1 -: SCORE_BITS]))) begin
          best_found <= 1'b1;
          best_box <= p_box;
          best_idx <= p_idx;
        end
      end
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (wr_en) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              state <= ST_SCAN;
              scnt <= '0;
              have_k <= 1'b0;
              best_found <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          iss_idx <= rd_addr;
          iss_act <= ~taken[rd_addr] & ~supp[rd_addr];
          scnt <= scnt + 1'b1;
          if (scnt == count - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (~iss_v & ~p_busy) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (~have_k | out_free) begin
            if (have_k) begin
              m_tvalid <= 1'b1;
              m_tdata <= DW'(kbox);
              m_tlast <= ~best_found;
              m_tuser <= ovf;
            end
            if (best_found) begin
              kbox <= best_box;
              taken[best_idx] <= 1'b1;
              have_k <= 1'b1;
              best_found <= 1'b0;
              scnt <= '0;
              state <= ST_SCAN;
            end else begin
              count <= '0;
              ovf <= 1'b0;
              taken <= '0;
              supp <= '0;
              have_k <= 1'b0;
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // store never fills past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_BOXES)) else $error("box count beyond capacity");
  // a box still eligible at the pipeline output was never taken as kept
  a_act_not_taken: assert property (@(posedge clk) disable iff (rst)
    (p_valid & p_act) |-> ~taken[p_idx]) else $error("taken box still eligible");
  // reads are issued only by the scan
  a_issue_scan: assert property (@(posedge clk) disable iff (rst)
    iss_v |-> $past(state) == ST_SCAN) else $error("read issued outside scan");
  // a selected kept box is always presented on the output
  a_emit_k: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NEXT & have_k & out_free) |=> m_tvalid) else $error("kept box lost");
endmodule
`default_nettype wire
